// File: rtl/core/qte_pkg.sv
package qte_pkg;

   localparam int COMP_FRAC_BITS  = 14;
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int WORK_FRAC       = 30;
   localparam int DEG_FRAC        = 24;
   localparam int WORK_SHIFT      = WORK_FRAC - 2 * COMP_FRAC_BITS;

   localparam int IN_W    = 16;
   localparam int PROD_W  = 32;
   localparam int ANGLE_W = 16;
   localparam int CW      = 38;   // cordic x/y datapath
   localparam int ZW      = 34;   // angle accumulator, degrees Q24
   localparam int A_W     = 32;   // pitch argument at Q30
   localparam int SQ_IN_W = 62;
   localparam int ROOT_W  = SQ_IN_W / 2;
   localparam int REM_W   = ROOT_W + 4;

   localparam int RND_SHIFT = DEG_FRAC - ANGLE_FRAC_BITS;
   localparam int ANGLE_LIM = ((180 << ANGLE_FRAC_BITS) > 32767) ? 32767
                                                               : (180 << ANGLE_FRAC_BITS);
   localparam longint DEG90 = 64'sd90 << DEG_FRAC;

   typedef logic signed [CW-1:0]      cw_type;
   typedef logic signed [ZW-1:0]      zw_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;

   typedef struct packed {
      logic signed [A_W-1:0] pitch_arg;
      cw_type                roll_num;
      cw_type                roll_den;
      cw_type                yaw_num;
      cw_type                yaw_den;
   } opnd_type;

   // atan(2^-i) in degrees, Q24
   function automatic logic [31:0] atan_deg(input int unsigned i);
      logic [31:0] v;
      case (i)
         0: v = 32'd754974720;
         1: v = 32'd445687602;
         2: v = 32'd235489088;
         3: v = 32'd119537938;
         4: v = 32'd60000934;
         5: v = 32'd30029717;
         6: v = 32'd15018523;
         7: v = 32'd7509720;
         8: v = 32'd3754917;
         9: v = 32'd1877466;
         10: v = 32'd938734;
         11: v = 32'd469367;
         12: v = 32'd234684;
         13: v = 32'd117342;
         14: v = 32'd58671;
         15: v = 32'd29335;
         16: v = 32'd14668;
         17: v = 32'd7334;
         18: v = 32'd3667;
         19: v = 32'd1833;
         20: v = 32'd917;
         21: v = 32'd458;
         22: v = 32'd229;
         23: v = 32'd115;
         24: v = 32'd57;
         25: v = 32'd29;
         26: v = 32'd14;
         27: v = 32'd7;
         28: v = 32'd4;
         29: v = 32'd2;
         30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/core/qte_sqrt.sv
module qte_sqrt import qte_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [SQ_IN_W-1:0] in_radicand,
   input  opnd_type           in_side,
   output logic               out_valid,
   output logic [ROOT_W-1:0]  out_root,
   output opnd_type           out_side
);

   localparam int PAIRS = SQ_IN_W / 2;

   logic [REM_W-1:0]   rem_ff  [PAIRS];
   logic [REM_W-1:0]   rem_in  [PAIRS];
   logic [ROOT_W-1:0]  root_ff [PAIRS];
   logic [ROOT_W-1:0]  root_in [PAIRS];
   logic [SQ_IN_W-1:0] rad_ff  [PAIRS];
   logic [SQ_IN_W-1:0] rad_in  [PAIRS];
   opnd_type           side_ff [PAIRS];
   opnd_type           side_in [PAIRS];
   logic               valid_ff [PAIRS];
   logic               valid_in [PAIRS];

   // one root bit per stage, restoring form
   always_comb begin
      logic [REM_W-1:0]   rem_prev, rem_sh, trial;
      logic [ROOT_W-1:0]  root_prev;
      logic [SQ_IN_W-1:0] rad_prev;
      for (int k = 0; k < PAIRS; k++) begin
         if (k == 0) begin
            rem_prev    = '0;
            root_prev   = '0;
            rad_prev    = in_radicand;
            side_in[k]  = in_side;
            valid_in[k] = in_valid;
         end else begin
            rem_prev    = rem_ff[k-1];
            root_prev   = root_ff[k-1];
            rad_prev    = rad_ff[k-1];
            side_in[k]  = side_ff[k-1];
            valid_in[k] = valid_ff[k-1];
         end
         rem_sh    = {rem_prev[REM_W-3:0], rad_prev[SQ_IN_W-1 -: 2]};
         trial     = REM_W'({root_prev, 2'b01});
         rad_in[k] = rad_prev << 2;
         if (rem_sh >= trial) begin
            rem_in[k]  = rem_sh - trial;
            root_in[k] = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem_sh;
            root_in[k] = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < PAIRS; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_in[k];
         end
         if (en) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid = valid_ff[PAIRS-1];
   assign out_root  = root_ff[PAIRS-1];
   assign out_side  = side_ff[PAIRS-1];

endmodule

// File: rtl/core/qte_cordic.sv
module qte_cordic import qte_pkg::*; #(
   parameter int STEPS = 16
) (
   input  logic      clock,
   input  logic      en,
   input  cw_type    in_y,
   input  cw_type    in_x,
   output angle_type out_angle
);

   cw_type    x_ff    [STEPS+1];
   cw_type    x_in    [STEPS+1];
   cw_type    y_ff    [STEPS+1];
   cw_type    y_in    [STEPS+1];
   zw_type    z_ff    [STEPS+1];
   zw_type    z_in    [STEPS+1];
   logic      zero_ff [STEPS+1];
   logic      zero_in [STEPS+1];
   angle_type angle_ff, angle_in;

   always_comb begin
      cw_type xs, ys;
      zero_in[0] = (in_x == '0) && (in_y == '0);
      if (in_x < 0) begin
         if (in_y >= 0) begin
            x_in[0] = in_y;
            y_in[0] = -in_x;
            z_in[0] = ZW'(DEG90);
         end else begin
            x_in[0] = -in_y;
            y_in[0] = in_x;
            z_in[0] = -ZW'(DEG90);
         end
      end else begin
         x_in[0] = in_x;
         y_in[0] = in_y;
         z_in[0] = '0;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
         zero_in[i+1] = zero_ff[i];
         if (y_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] + ys;
            y_in[i+1] = y_ff[i] - xs;
            z_in[i+1] = z_ff[i] + zw_type'(ZW'(atan_deg(i)));
         end else begin
            x_in[i+1] = x_ff[i] - ys;
            y_in[i+1] = y_ff[i] + xs;
            z_in[i+1] = z_ff[i] - zw_type'(ZW'(atan_deg(i)));
         end
      end
   end

   // round half away from zero, saturate
   always_comb begin
      logic [ZW-1:0] mag, rnd;
      zw_type        zf;
      zf  = zero_ff[STEPS] ? '0 : z_ff[STEPS];
      mag = zf[ZW-1] ? ZW'(-zf) : ZW'(zf);
      rnd = (mag + (ZW'(1) << (RND_SHIFT - 1))) >> RND_SHIFT;
      if (rnd > ZW'(ANGLE_LIM)) rnd = ZW'(ANGLE_LIM);
      angle_in = zf[ZW-1] ? -angle_type'(rnd[ANGLE_W-1:0]) : angle_type'(rnd[ANGLE_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= STEPS; i++) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
            zero_ff[i] <= zero_in[i];
         end
         angle_ff <= angle_in;
      end
   end

   assign out_angle = angle_ff;

endmodule

// File: rtl/core/quaternion_to_euler_angles.sv
// ZYX Euler angles from a Q2.14 attitude quaternion, in 1/128 degree. One item
// enters per clock; the steps are products, sums, squaring and subtraction, a
// bit-per-stage square root for the pitch cosine, then three parallel CORDIC
// atan2 pipelines (quadrant stage, one stage per step, rounding). When the
// result is not taken, every stage holds.
module quaternion_to_euler_angles import qte_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [IN_W-1:0] req_quat_w,
   input  logic signed [IN_W-1:0] req_quat_x,
   input  logic signed [IN_W-1:0] req_quat_y,
   input  logic signed [IN_W-1:0] req_quat_z,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output angle_type              rsp_pitch_angle,
   output angle_type              rsp_roll_angle,
   output angle_type              rsp_yaw_angle
);

   localparam int LAT = CORDIC_STEPS + 2;
   localparam logic signed [33:0] ONE_Q = 34'sd1 <<< (2 * COMP_FRAC_BITS);
   localparam logic [SQ_IN_W-1:0] ONE_SQ = SQ_IN_W'(1) << (2 * WORK_FRAC);

   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // stage 1: products
   logic signed [PROD_W-1:0] wy_ff, xz_ff, wx_ff, yz_ff, wz_ff, xy_ff, xx_ff, yy_ff, zz_ff;
   logic                     v1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_valid;
      if (en) begin
         wy_ff <= req_quat_w * req_quat_y;
         xz_ff <= req_quat_x * req_quat_z;
         wx_ff <= req_quat_w * req_quat_x;
         yz_ff <= req_quat_y * req_quat_z;
         wz_ff <= req_quat_w * req_quat_z;
         xy_ff <= req_quat_x * req_quat_y;
         xx_ff <= req_quat_x * req_quat_x;
         yy_ff <= req_quat_y * req_quat_y;
         zz_ff <= req_quat_z * req_quat_z;
      end
   end

   // stage 2: atan2 operands at Q30
   opnd_type s2_ff, s2_in;
   logic     v2_ff;

   always_comb begin
      logic signed [33:0] a_raw, a_cl;
      a_raw = (34'(wy_ff) - 34'(xz_ff)) <<< 1;
      if (a_raw > ONE_Q) a_cl = ONE_Q;
      else if (a_raw < -ONE_Q) a_cl = -ONE_Q;
      else a_cl = a_raw;
      s2_in.pitch_arg = A_W'(a_cl) <<< WORK_SHIFT;
      s2_in.roll_num  = ((CW'(wx_ff) + CW'(yz_ff)) <<< 1) <<< WORK_SHIFT;
      s2_in.roll_den  = (CW'(ONE_Q) - ((CW'(xx_ff) + CW'(yy_ff)) <<< 1)) <<< WORK_SHIFT;
      s2_in.yaw_num   = ((CW'(wz_ff) + CW'(xy_ff)) <<< 1) <<< WORK_SHIFT;
      s2_in.yaw_den   = (CW'(ONE_Q) - ((CW'(yy_ff) + CW'(zz_ff)) <<< 1)) <<< WORK_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
      if (en) s2_ff <= s2_in;
   end

   // stage 3: square of pitch argument
   opnd_type           s3_ff;
   logic [SQ_IN_W-1:0] a2_ff, a2_in;
   logic [ROOT_W-1:0]  a_mag;
   logic               v3_ff;

   assign a_mag = s2_ff.pitch_arg[A_W-1] ? ROOT_W'(-s2_ff.pitch_arg)
                                         : ROOT_W'(s2_ff.pitch_arg);
   assign a2_in = SQ_IN_W'(a_mag) * SQ_IN_W'(a_mag);

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
      if (en) begin
         a2_ff <= a2_in;
         s3_ff <= s2_ff;
      end
   end

   // stage 4: 1 - a^2
   opnd_type           s4_ff;
   logic [SQ_IN_W-1:0] rad_ff, rad_in;
   logic               v4_ff;

   assign rad_in = ONE_SQ - a2_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
      if (en) begin
         rad_ff <= rad_in;
         s4_ff  <= s3_ff;
      end
   end

   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   opnd_type          sq_side;

   qte_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (v4_ff),
      .in_radicand (rad_ff),
      .in_side     (s4_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   logic vc_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) vc_ff[0] <= 1'b0;
      else if (en) vc_ff[0] <= sq_valid;
      for (int i = 1; i < LAT; i++) begin
         if (reset) vc_ff[i] <= 1'b0;
         else if (en) vc_ff[i] <= vc_ff[i-1];
      end
   end

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
      .clock     (clock),
      .en        (en),
      .in_y      (CW'(sq_side.pitch_arg)),
      .in_x      (cw_type'({{(CW-ROOT_W){1'b0}}, sq_root})),
      .out_angle (rsp_pitch_angle)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
      .clock     (clock),
      .en        (en),
      .in_y      (sq_side.roll_num),
      .in_x      (sq_side.roll_den),
      .out_angle (rsp_roll_angle)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
      .clock     (clock),
      .en        (en),
      .in_y      (sq_side.yaw_num),
      .in_x      (sq_side.yaw_den),
      .out_angle (rsp_yaw_angle)
   );

   assign rsp_valid = vc_ff[LAT-1];

`ifndef ASSERT_OFF
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= ANGLE_LIM) && (rsp_pitch_angle >= -ANGLE_LIM))
      else $error("pitch out of range");
   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle <= ANGLE_LIM) && (rsp_roll_angle >= -ANGLE_LIM))
      else $error("roll out of range");
   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_yaw_angle <= ANGLE_LIM) && (rsp_yaw_angle >= -ANGLE_LIM))
      else $error("yaw out of range");
`endif

endmodule

// File: bench/quaternion_to_euler_angles_tb.sv
module quaternion_to_euler_angles_tb;
   import qte_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS   = 16;
   localparam int LATENCY = STEPS + 37;

   typedef struct {
      angle_type pitch;
      angle_type roll;
      angle_type yaw;
   } euler_type;

   // floor shift for signed 64-bit values
   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint to_q30(longint v);
      if (2 * COMP_FRAC_BITS < WORK_FRAC)
         return v * (64'sd1 <<< (WORK_FRAC - 2 * COMP_FRAC_BITS));
      return shr_floor(v, 2 * COMP_FRAC_BITS - WORK_FRAC);
   endfunction

   function automatic longint floor_sqrt(longint unsigned n);
      longint unsigned root, bit_v;
      root = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= root + bit_v) begin
            n -= root + bit_v;
            root = (root >> 1) + bit_v;
         end else begin
            root >>= 1;
         end
         bit_v >>= 2;
      end
      return root;
   endfunction

   function automatic longint atan_table(int i);
      longint t [0:31] = '{754974720, 445687602, 235489088, 119537938, 60000934,
         30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
         117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
         29, 14, 7, 4, 2, 1, 0};
      return t[i];
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint ang, tmp, xs, ys;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         tmp = x;
         if (y >= 0) begin
            x = y; y = -tmp; ang = 64'sd90 <<< DEG_FRAC;
         end else begin
            x = -y; y = tmp; ang = -(64'sd90 <<< DEG_FRAC);
         end
      end
      for (int i = 0; i < STEPS && i < 32; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; ang += atan_table(i);
         end else begin
            x -= ys; y += xs; ang -= atan_table(i);
         end
      end
      return ang;
   endfunction

   function automatic angle_type round_degrees(longint ang);
      longint unsigned mag;
      longint lim, r;
      int s;
      s = DEG_FRAC - ANGLE_FRAC_BITS;
      lim = 180 << ANGLE_FRAC_BITS;
      mag = (ang < 0) ? -ang : ang;
      if (s > 0) mag = (mag + (64'd1 << (s - 1))) >> s;
      if (lim > 32767) lim = 32767;
      if (mag > lim) mag = lim;
      r = (ang < 0) ? -longint'(mag) : longint'(mag);
      return angle_type'(r);
   endfunction

   function automatic euler_type predict_euler(longint w, longint x, longint y, longint z);
      euler_type e;
      longint unit_v, arg, arg30, cos30;
      longint unsigned sq;
      unit_v = 64'sd1 <<< (2 * COMP_FRAC_BITS);
      arg = 2 * (w * y - x * z);
      if (arg > unit_v) arg = unit_v;
      if (arg < -unit_v) arg = -unit_v;
      arg30 = to_q30(arg);
      sq = (arg30 < 0) ? -arg30 : arg30;
      sq = sq * sq;
      cos30 = floor_sqrt((64'd1 << (2 * WORK_FRAC)) - sq);
      e.pitch = round_degrees(vector_angle(arg30, cos30));
      e.roll  = round_degrees(vector_angle(to_q30(2 * (w * x + y * z)),
                                           to_q30(unit_v - 2 * (x * x + y * y))));
      e.yaw   = round_degrees(vector_angle(to_q30(2 * (w * z + x * y)),
                                           to_q30(unit_v - 2 * (y * y + z * z))));
      return e;
   endfunction

   class euler_board;
      euler_type pending[$];
      int errors;

      function void note_quat(longint w, longint x, longint y, longint z);
         pending.push_back(predict_euler(w, x, y, z));
      endfunction

      function void check_angles(angle_type p, angle_type r, angle_type yw);
         euler_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected item p=%0d r=%0d y=%0d", $time, p, r, yw);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (e.pitch !== p) begin
            $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, p);
            errors++;
         end
         if (e.roll !== r) begin
            $display("%0t: roll expected %0d actual %0d", $time, e.roll, r);
            errors++;
         end
         if (e.yaw !== yw) begin
            $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, yw);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [IN_W-1:0] req_quat_w = 0, req_quat_x = 0, req_quat_y = 0, req_quat_z = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   angle_type rsp_pitch_angle, rsp_roll_angle, rsp_yaw_angle;
   euler_board board = new();
   logic long_hold = 0;
   logic stim_done = 0;

   quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note_quat(req_quat_w, req_quat_x, req_quat_y, req_quat_z);
      if (!reset && rsp_valid && rsp_ready)
         board.check_angles(rsp_pitch_angle, rsp_roll_angle, rsp_yaw_angle);
   end

   task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
      req_valid <= 1;
      req_quat_w <= w; req_quat_x <= x; req_quat_y <= y; req_quat_z <= z;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic idle_sender(int n);
      req_valid <= 0;
      repeat (n) @(negedge clock);
   endtask

   // random quaternion, components in [-1.0, 1.0) in Q2.14, or one with roll near +/-90 degrees
   task automatic send_unit_like();
      int a, b, c, d, s;
      a = $urandom_range(0, 32767) - 16384;
      b = $urandom_range(0, 32767) - 16384;
      c = $urandom_range(0, 32767) - 16384;
      d = $urandom_range(0, 32767) - 16384;
      s = $urandom_range(0, 3);
      if (s == 0) begin
         c = $urandom_range(0, 8) - 4; // roll near +/-90 degrees
         a = 11585; b = 11585 * (($urandom_range(0, 1)) ? 1 : -1);
         d = 0;
      end
      send_quat(16'(a), 16'(b), 16'(c), 16'(d));
   endtask

   // receiver stall pattern
   initial begin
      int r;
      @(negedge clock);
      forever begin
         r = $urandom_range(0, 15);
         if (long_hold)
            rsp_ready <= 0;
         else if (r < 6)
            rsp_ready <= 1;
         else if (r < 12)
            rsp_ready <= (r % 2 == 0);
         else
            rsp_ready <= 0;
         @(negedge clock);
      end
   end

   initial begin
      logic [15:0] edges [0:5] = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000, 16'hffff};
      int cnt;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed
      send_quat(16'h4000, 0, 0, 0);
      send_quat(0, 0, 0, 0);
      send_quat(16'h2d41, 0, 16'h2d41, 0);
      send_quat(16'h2d41, 0, 16'hd2bf, 0);
      send_quat(16'h2d41, 16'h2d41, 0, 0);
      send_quat(0, 16'h4000, 0, 0);
      send_quat(0, 0, 0, 16'h4000);
      send_quat(0, 0, 16'h4000, 0);
      send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_quat(16'h4000, 16'h7fff, 0, 16'h8000);
      send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
      for (int i = 0; i < 6; i++)
         send_quat(edges[i], edges[5 - i], edges[(i + 2) % 6], edges[(i + 4) % 6]);
      // fill the pipe while the receiver holds off
      long_hold = 1;
      fork
         begin
            repeat (LATENCY * 3) @(negedge clock);
            long_hold = 0;
         end
         repeat (80) send_unit_like();
      join
      // pause until drained
      idle_sender(1);
      while (board.pending.size() != 0) @(negedge clock);
      cnt = 0;
      while (cnt < 1000) begin
         int burst;
         burst = $urandom_range(1, 30);
         for (int k = 0; k < burst; k++) begin
            if ($urandom_range(0, 3) == 0)
               send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else
               send_unit_like();
            cnt++;
         end
         if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
      end
      idle_sender(1);
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #400000;
      $display("Some tests failed");
      $finish;
   end
endmodule
